// ===== rtl/core/bta_pkg.sv =====
package bta_pkg;

	localparam int STORE_BITS = 14;
	localparam int HANDLE_W   = 10;
	localparam int BYTES_W    = 13;

	typedef enum logic [1:0] {
		CMD_ALLOC = 2'd0,
		CMD_FREE  = 2'd1,
		CMD_QUERY = 2'd2,
		CMD_WALK  = 2'd3
	} cmd_t;

	typedef enum logic [5:0] {
		ST_IDLE, ST_FIN,
		ST_A_NEED, ST_A_CHK, ST_A_NX, ST_A_FIT, ST_A_DIVN, ST_A_DIVF, ST_A_PRV, ST_A_NXT,
		ST_A_W1, ST_A_W2, ST_A_W3, ST_A_W4, ST_A_W5, ST_A_PR, ST_A_PW, ST_A_NR, ST_A_NW,
		ST_A_U1, ST_A_U2, ST_A_END,
		ST_F_SZ, ST_F_IW, ST_F_L, ST_F_R, ST_F_RV, ST_F_CASE,
		ST_F0_1, ST_F0_2, ST_F0_3, ST_F0_4, ST_F0_5,
		ST_F1_A, ST_F1_B, ST_F1_C, ST_F1_D, ST_F1_E, ST_F1_F, ST_F1_G, ST_F1_H, ST_F1_I,
		ST_F1_J, ST_F1_K, ST_F1_L, ST_F1_M,
		ST_F2_A, ST_F2_B,
		ST_F3_A, ST_F3_B, ST_F3_C, ST_F3_D, ST_F3_E, ST_F3_F, ST_F3_G, ST_F3_H,
		ST_Q_START, ST_Q_CHK, ST_Q_NX, ST_Q_SZ, ST_Q_OUT,
		ST_W_T
	} state_t;

	typedef struct packed {
		logic rd_en;
		logic wr_en;
	} mem_ctl_t;

endpackage

// ===== rtl/core/bta_store.sv =====
module bta_store #(
	parameter int STORE_WORDS = 1024,
	parameter int WORD_BYTES  = 4,
	parameter int ADDR_W      = 17
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  bta_pkg::mem_ctl_t                        mc,
	input  logic signed [ADDR_W-1:0]                 rd_addr,
	input  logic signed [ADDR_W-1:0]                 wr_addr,
	input  logic signed [ADDR_W-1:0]                 wr_data,
	output logic signed [bta_pkg::STORE_BITS-1:0]    rd_data,
	output logic                                     init_busy
);
	import bta_pkg::*;

	localparam int LW = $clog2(STORE_WORDS);
	localparam logic signed [ADDR_W-1:0] SWX = ADDR_W'(STORE_WORDS);
	localparam logic [STORE_BITS-1:0] TOP_TAG = STORE_BITS'(-(STORE_WORDS * WORD_BYTES));
	localparam logic [STORE_BITS-1:0] END_LINK = STORE_BITS'(STORE_WORDS);

	logic [STORE_BITS-1:0] mem [STORE_WORDS];
	logic [STORE_BITS-1:0] rd_q;
	logic                  rd_ok_q;
	logic                  clr_busy_q;
	logic [LW-1:0]         clr_idx_q;
	logic                  we;
	logic [LW-1:0]         wa;
	logic [STORE_BITS-1:0] wd;
	logic                  rd_in;
	logic                  wr_in;

	assign rd_in = (rd_addr >= 0) && (rd_addr < SWX);
	assign wr_in = (wr_addr >= 0) && (wr_addr < SWX);

	always_comb begin
		if (clr_busy_q) begin
			we = 1'b1;
			wa = clr_idx_q;
			if (clr_idx_q == '0 || clr_idx_q == LW'(STORE_WORDS - 1))
				wd = TOP_TAG;
			else if (clr_idx_q == LW'(1))
				wd = '1;
			else if (clr_idx_q == LW'(2))
				wd = END_LINK;
			else
				wd = '0;
		end else begin
			we = mc.wr_en && wr_in;
			wa = wr_addr[LW-1:0];
			wd = wr_data[STORE_BITS-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[wa] <= wd;
		if (mc.rd_en) begin
			rd_q    <= mem[rd_addr[LW-1:0]];
			rd_ok_q <= rd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clr_busy_q) begin
			clr_idx_q <= clr_idx_q + LW'(1);
			if (clr_idx_q == LW'(STORE_WORDS - 1))
				clr_busy_q <= 1'b0;
		end
	end

	assign rd_data   = rd_ok_q ? rd_q : '0;
	assign init_busy = clr_busy_q;

endmodule

// ===== rtl/core/bta_ctrl.sv =====
module bta_ctrl #(
	parameter int STORE_WORDS    = 1024,
	parameter int WORD_BYTES     = 4,
	parameter int FREE_TAG_WORDS = 4,
	parameter int ADDR_W         = 17
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  bta_pkg::cmd_t                         cmd,
	input  logic [bta_pkg::BYTES_W-1:0]           byte_count,
	input  logic [bta_pkg::HANDLE_W-1:0]          handle,
	input  logic                                  restart,
	input  logic                                  init_busy,
	input  logic signed [bta_pkg::STORE_BITS-1:0] rd_data,
	output bta_pkg::mem_ctl_t                     mc,
	output logic signed [ADDR_W-1:0]              rd_addr,
	output logic signed [ADDR_W-1:0]              wr_addr,
	output logic signed [ADDR_W-1:0]              wr_data,
	output logic                                  busy,
	output logic                                  done,
	output logic [bta_pkg::HANDLE_W-1:0]          result_handle,
	output logic                                  ok,
	output logic [bta_pkg::BYTES_W-1:0]           block_bytes,
	output logic                                  block_free
);
	import bta_pkg::*;

	localparam int X  = ADDR_W;
	localparam int LW = $clog2(STORE_WORDS);
	localparam int DK = 16 + $clog2(WORD_BYTES);
	localparam longint DM = ((64'd1 <<< DK) + WORD_BYTES - 1) / WORD_BYTES;
	localparam logic signed [X-1:0] SWX   = X'(STORE_WORDS);
	localparam logic signed [X-1:0] WBX   = X'(WORD_BYTES);
	localparam logic signed [X-1:0] TWB   = X'(2 * WORD_BYTES);
	localparam logic signed [X-1:0] THR   = X'(WORD_BYTES * FREE_TAG_WORDS);
	localparam logic signed [X-1:0] NEG1  = '1;
	localparam logic signed [X-1:0] ONE   = X'(1);
	localparam logic signed [X-1:0] TWO   = X'(2);
	localparam logic signed [X-1:0] THREE = X'(3);
	localparam logic [LW:0] SW_H    = (LW+1)'(STORE_WORDS);
	localparam logic [LW:0] STEP_LT = (LW+1)'(STORE_WORDS - 1);

	function automatic logic [15:0] div_wb(input logic [15:0] x);
		logic [DK+16:0] pr;
		pr = (DK+17)'(x) * (DK+17)'(DM);
		return pr[DK +: 16];
	endfunction

	function automatic logic in_st(input logic signed [X-1:0] v);
		return (v >= 0) && (v < SWX);
	endfunction

	function automatic logic [LW:0] head_of(input logic signed [X-1:0] v);
		return in_st(v) ? v[LW:0] : SW_H;
	endfunction

	state_t state_q, state_d;
	logic [LW:0] head_q, head_d, cur_q, cur_d, steps_q, steps_d;
	logic signed [X-1:0] p_q, p_d, need_q, need_d, sz_q, sz_d, rem_q, rem_d;
	logic signed [X-1:0] iw_q, iw_d, tw_q, tw_d, prv_q, prv_d, nxt_q, nxt_d;
	logic signed [X-1:0] lsz_q, lsz_d, rsz_q, rsz_d, tot_q, tot_d;
	logic first_q, first_d, f_q, f_d;
	logic [HANDLE_W-1:0] h_q, h_d;
	logic [BYTES_W-1:0]  n_q, n_d;
	logic                fin, fin_ok, fin_bf;
	logic signed [X-1:0] fin_rh, fin_bb;
	logic                done_q, ok_q, bf_q;
	logic [HANDLE_W-1:0] rh_q;
	logic [BYTES_W-1:0]  bb_q;
	logic signed [X-1:0] rdx, rmag, headx, hx;

	assign rdx   = X'(rd_data);
	assign rmag  = rdx[X-1] ? -rdx : rdx;
	assign headx = X'(head_q);
	assign hx    = X'(h_q);

	always_comb begin
		logic [LW:0]         curw;
		logic [15:0]         nq;
		logic signed [X-1:0] rx, nd, lm, rm, endv, nc;
		state_d = state_q; head_d = head_q; cur_d = cur_q; steps_d = steps_q;
		p_d = p_q; need_d = need_q; sz_d = sz_q; rem_d = rem_q; iw_d = iw_q; tw_d = tw_q;
		prv_d = prv_q; nxt_d = nxt_q; lsz_d = lsz_q; rsz_d = rsz_q; tot_d = tot_q;
		first_d = first_q; f_d = f_q; h_d = h_q; n_d = n_q;
		mc = '0; rd_addr = '0; wr_addr = '0; wr_data = '0;
		fin = 1'b0; fin_ok = 1'b0; fin_bf = 1'b0; fin_rh = '0; fin_bb = '0;
		curw = '0; nq = '0; rx = '0; nd = '0; lm = '0; rm = '0; endv = '0; nc = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start && !init_busy) begin
					h_d = handle;
					n_d = byte_count;
					f_d = 1'b0;
					unique case (cmd)
						CMD_ALLOC: state_d = ST_A_NEED;
						CMD_FREE: begin
							p_d = X'(handle) - ONE;
							mc.rd_en = 1'b1;
							rd_addr = X'(handle) - ONE;
							state_d = ST_F_SZ;
						end
						CMD_QUERY: state_d = ST_Q_START;
						CMD_WALK: begin
							curw = restart ? '0 : cur_q;
							cur_d = curw;
							if (curw < SW_H) begin
								p_d = X'(curw);
								mc.rd_en = 1'b1;
								rd_addr = X'(curw);
								state_d = ST_W_T;
							end else
								state_d = ST_FIN;
						end
						default: state_d = ST_FIN;
					endcase
				end
			end
			ST_FIN: begin
				fin = 1'b1;
				state_d = ST_IDLE;
			end
			ST_A_NEED: begin
				nq = div_wb(16'(n_q));
				rx = X'(n_q) - X'(nq) * WBX;
				nd = X'(n_q) + ((rx != '0) ? WBX - rx : '0) + TWB;
				need_d = (nd < THR) ? THR : nd;
				if (head_q >= SW_H)
					state_d = ST_FIN;
				else begin
					p_d = headx;
					steps_d = '0;
					first_d = 1'b1;
					mc.rd_en = 1'b1;
					rd_addr = headx;
					state_d = ST_A_CHK;
				end
			end
			ST_A_CHK: begin
				if (rmag >= need_q) begin
					sz_d = rmag;
					rem_d = rmag - need_q;
					state_d = ST_A_FIT;
				end else begin
					mc.rd_en = 1'b1;
					rd_addr = p_q + TWO;
					state_d = ST_A_NX;
				end
			end
			ST_A_NX: begin
				if (!in_st(rdx) || steps_q == STEP_LT)
					state_d = ST_FIN;
				else begin
					steps_d = steps_q + (LW+1)'(1);
					p_d = rdx;
					first_d = 1'b0;
					mc.rd_en = 1'b1;
					rd_addr = rdx;
					state_d = ST_A_CHK;
				end
			end
			ST_A_FIT: begin
				if (rem_q <= THR) begin
					need_d = need_q + rem_q;
					rem_d = '0;
				end
				state_d = ST_A_DIVN;
			end
			ST_A_DIVN: begin
				iw_d = X'(div_wb(need_q[15:0]));
				state_d = ST_A_DIVF;
			end
			ST_A_DIVF: begin
				tw_d = X'(div_wb(sz_q[15:0]));
				mc.rd_en = 1'b1;
				rd_addr = p_q + ONE;
				state_d = ST_A_PRV;
			end
			ST_A_PRV: begin
				prv_d = rdx;
				mc.rd_en = 1'b1;
				rd_addr = p_q + TWO;
				state_d = ST_A_NXT;
			end
			ST_A_NXT: begin
				nxt_d = rdx;
				mc.wr_en = 1'b1; wr_addr = p_q; wr_data = need_q;
				state_d = ST_A_W1;
			end
			ST_A_W1: begin
				mc.wr_en = 1'b1; wr_addr = p_q + iw_q - ONE; wr_data = need_q;
				state_d = (rem_q > 0) ? ST_A_W2 : ST_A_U1;
			end
			ST_A_W2: begin
				mc.wr_en = 1'b1; wr_addr = p_q + iw_q; wr_data = -rem_q;
				state_d = ST_A_W3;
			end
			ST_A_W3: begin
				mc.wr_en = 1'b1; wr_addr = p_q + tw_q - ONE; wr_data = -rem_q;
				state_d = ST_A_W4;
			end
			ST_A_W4: begin
				mc.wr_en = 1'b1; wr_addr = p_q + iw_q + ONE; wr_data = prv_q;
				state_d = ST_A_W5;
			end
			ST_A_W5: begin
				mc.wr_en = 1'b1; wr_addr = p_q + iw_q + TWO; wr_data = nxt_q;
				state_d = ST_A_PR;
			end
			ST_A_PR: begin
				if (prv_q != NEG1) begin
					mc.rd_en = 1'b1;
					rd_addr = prv_q + TWO;
					state_d = ST_A_PW;
				end else
					state_d = ST_A_NR;
			end
			ST_A_PW: begin
				mc.wr_en = 1'b1; wr_addr = prv_q + TWO; wr_data = rdx + iw_q;
				state_d = ST_A_NR;
			end
			ST_A_NR: begin
				if (nxt_q != SWX) begin
					mc.rd_en = 1'b1;
					rd_addr = nxt_q + ONE;
					state_d = ST_A_NW;
				end else
					state_d = ST_A_END;
			end
			ST_A_NW: begin
				mc.wr_en = 1'b1; wr_addr = nxt_q + ONE; wr_data = rdx + iw_q;
				state_d = ST_A_END;
			end
			ST_A_U1: begin
				if (prv_q != NEG1) begin
					mc.wr_en = 1'b1; wr_addr = prv_q + TWO; wr_data = nxt_q;
				end
				state_d = ST_A_U2;
			end
			ST_A_U2: begin
				if (nxt_q != SWX) begin
					mc.wr_en = 1'b1; wr_addr = nxt_q + ONE; wr_data = prv_q;
				end
				state_d = ST_A_END;
			end
			ST_A_END: begin
				if (first_q)
					head_d = (rem_q > 0) ? head_of(headx + iw_q) : head_of(nxt_q);
				fin = 1'b1;
				fin_ok = 1'b1;
				fin_rh = p_q + ONE;
				state_d = ST_IDLE;
			end
			ST_F_SZ: begin
				sz_d = rmag;
				state_d = ST_F_IW;
			end
			ST_F_IW: begin
				iw_d = X'(div_wb(sz_q[15:0]));
				if (p_q > 0) begin
					mc.rd_en = 1'b1;
					rd_addr = p_q - ONE;
					state_d = ST_F_L;
				end else begin
					lsz_d = '0;
					state_d = ST_F_R;
				end
			end
			ST_F_L: begin
				lsz_d = rdx;
				state_d = ST_F_R;
			end
			ST_F_R: begin
				if (SWX - ONE > p_q + iw_q - ONE) begin
					mc.rd_en = 1'b1;
					rd_addr = p_q + iw_q;
					state_d = ST_F_RV;
				end else begin
					rsz_d = '0;
					state_d = ST_F_CASE;
				end
			end
			ST_F_RV: begin
				rsz_d = rdx;
				state_d = ST_F_CASE;
			end
			ST_F_CASE: begin
				lm = lsz_q[X-1] ? -lsz_q : '0;
				rm = rsz_q[X-1] ? -rsz_q : '0;
				tot_d = sz_q + lm + rm;
				rem_d = sz_q + rm;
				unique case ({lsz_q[X-1], rsz_q[X-1]})
					2'b00: state_d = ST_F0_1;
					2'b01: state_d = ST_F1_A;
					2'b10: state_d = ST_F2_A;
					default: state_d = ST_F3_A;
				endcase
			end
			ST_F0_1: begin
				mc.wr_en = 1'b1; wr_addr = p_q + ONE; wr_data = NEG1;
				state_d = ST_F0_2;
			end
			ST_F0_2: begin
				mc.wr_en = 1'b1; wr_addr = p_q; wr_data = -sz_q;
				state_d = ST_F0_3;
			end
			ST_F0_3: begin
				mc.wr_en = 1'b1; wr_addr = p_q + iw_q - ONE; wr_data = -sz_q;
				state_d = ST_F0_4;
			end
			ST_F0_4: begin
				mc.wr_en = 1'b1; wr_addr = p_q + TWO; wr_data = headx;
				state_d = ST_F0_5;
			end
			ST_F0_5: begin
				if (head_q < SW_H) begin
					mc.wr_en = 1'b1; wr_addr = headx + ONE; wr_data = p_q;
				end
				head_d = head_of(p_q);
				state_d = ST_FIN;
			end
			ST_F1_A: begin
				mc.rd_en = 1'b1;
				rd_addr = p_q + iw_q + ONE;
				state_d = ST_F1_B;
			end
			ST_F1_B: begin
				prv_d = rdx;
				mc.rd_en = 1'b1;
				rd_addr = p_q + iw_q + TWO;
				state_d = ST_F1_C;
			end
			ST_F1_C: begin
				nxt_d = rdx;
				state_d = ST_F1_D;
			end
			ST_F1_D: begin
				tw_d = X'(div_wb(tot_q[15:0]));
				mc.wr_en = 1'b1; wr_addr = p_q; wr_data = -tot_q;
				state_d = ST_F1_E;
			end
			ST_F1_E: begin
				mc.wr_en = 1'b1; wr_addr = p_q + tw_q - ONE; wr_data = -tot_q;
				state_d = ST_F1_F;
			end
			ST_F1_F: begin
				if (prv_q != NEG1) begin
					mc.rd_en = 1'b1;
					rd_addr = prv_q + TWO;
					state_d = ST_F1_G;
				end else
					state_d = ST_F1_H;
			end
			ST_F1_G: begin
				mc.wr_en = 1'b1; wr_addr = prv_q + TWO; wr_data = rdx - iw_q;
				state_d = ST_F1_H;
			end
			ST_F1_H: begin
				if (nxt_q != SWX) begin
					mc.rd_en = 1'b1;
					rd_addr = nxt_q + ONE;
					state_d = ST_F1_I;
				end else
					state_d = ST_F1_J;
			end
			ST_F1_I: begin
				mc.wr_en = 1'b1; wr_addr = nxt_q + ONE; wr_data = rdx - iw_q;
				state_d = ST_F1_J;
			end
			ST_F1_J: begin
				mc.rd_en = 1'b1;
				rd_addr = p_q + iw_q + ONE;
				state_d = ST_F1_K;
			end
			ST_F1_K: begin
				mc.wr_en = 1'b1; wr_addr = p_q + ONE; wr_data = rdx;
				state_d = ST_F1_L;
			end
			ST_F1_L: begin
				mc.rd_en = 1'b1;
				rd_addr = p_q + iw_q + TWO;
				state_d = ST_F1_M;
			end
			ST_F1_M: begin
				mc.wr_en = 1'b1; wr_addr = p_q + TWO; wr_data = rdx;
				if (headx == p_q + iw_q)
					head_d = head_of(p_q);
				state_d = ST_FIN;
			end
			ST_F2_A: begin
				mc.wr_en = 1'b1;
				wr_addr = p_q - X'(div_wb(16'(-lsz_q)));
				wr_data = -tot_q;
				state_d = ST_F2_B;
			end
			ST_F2_B: begin
				mc.wr_en = 1'b1; wr_addr = p_q + iw_q - ONE; wr_data = -tot_q;
				state_d = ST_FIN;
			end
			ST_F3_A: begin
				mc.wr_en = 1'b1;
				wr_addr = p_q - X'(div_wb(16'(-lsz_q)));
				wr_data = -tot_q;
				state_d = ST_F3_B;
			end
			ST_F3_B: begin
				mc.wr_en = 1'b1;
				wr_addr = p_q + X'(div_wb(rem_q[15:0])) - ONE;
				wr_data = -tot_q;
				state_d = ST_F3_C;
			end
			ST_F3_C: begin
				mc.rd_en = 1'b1;
				rd_addr = p_q + iw_q + ONE;
				state_d = ST_F3_D;
			end
			ST_F3_D: begin
				prv_d = rdx;
				mc.rd_en = 1'b1;
				rd_addr = p_q + iw_q + TWO;
				state_d = ST_F3_E;
			end
			ST_F3_E: begin
				nxt_d = rdx;
				state_d = ST_F3_F;
			end
			ST_F3_F: begin
				if (prv_q != NEG1) begin
					mc.wr_en = 1'b1; wr_addr = prv_q + TWO; wr_data = nxt_q;
					state_d = ST_F3_G;
				end else begin
					head_d = head_of(nxt_q);
					state_d = ST_F3_H;
				end
			end
			ST_F3_G: begin
				if (nxt_q != SWX) begin
					mc.wr_en = 1'b1; wr_addr = nxt_q + ONE; wr_data = prv_q;
				end
				state_d = ST_FIN;
			end
			ST_F3_H: begin
				if (head_q < SW_H) begin
					mc.wr_en = 1'b1; wr_addr = headx + ONE; wr_data = NEG1;
				end
				state_d = ST_FIN;
			end
			ST_Q_START: begin
				if (head_q >= SW_H)
					state_d = ST_Q_SZ;
				else begin
					p_d = headx;
					steps_d = '0;
					mc.rd_en = 1'b1;
					rd_addr = headx;
					state_d = ST_Q_CHK;
				end
			end
			ST_Q_CHK: begin
				endv = p_q + X'(div_wb(rmag[15:0]));
				if (p_q < hx && hx < endv) begin
					f_d = 1'b1;
					state_d = ST_Q_SZ;
				end else begin
					mc.rd_en = 1'b1;
					rd_addr = p_q + TWO;
					state_d = ST_Q_NX;
				end
			end
			ST_Q_NX: begin
				if (!in_st(rdx) || steps_q == STEP_LT)
					state_d = ST_Q_SZ;
				else begin
					steps_d = steps_q + (LW+1)'(1);
					p_d = rdx;
					mc.rd_en = 1'b1;
					rd_addr = rdx;
					state_d = ST_Q_CHK;
				end
			end
			ST_Q_SZ: begin
				mc.rd_en = 1'b1;
				rd_addr = hx - (f_q ? THREE : ONE);
				state_d = ST_Q_OUT;
			end
			ST_Q_OUT: begin
				fin = 1'b1;
				fin_bb = rmag;
				fin_bf = f_q;
				state_d = ST_IDLE;
			end
			ST_W_T: begin
				nc = p_q + X'(div_wb(rmag[15:0]));
				cur_d = (nc > SWX) ? SW_H : nc[LW:0];
				fin = 1'b1;
				fin_ok = 1'b1;
				fin_rh = rdx[X-1] ? p_q + THREE : p_q + ONE;
				fin_bb = rmag;
				fin_bf = rdx[X-1];
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q  <= '0;
			cur_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			cur_q   <= cur_d;
			done_q  <= fin;
		end
	end

	always_ff @(posedge clk) begin
		steps_q <= steps_d; p_q <= p_d; need_q <= need_d; sz_q <= sz_d; rem_q <= rem_d;
		iw_q <= iw_d; tw_q <= tw_d; prv_q <= prv_d; nxt_q <= nxt_d;
		lsz_q <= lsz_d; rsz_q <= rsz_d; tot_q <= tot_d;
		first_q <= first_d; f_q <= f_d; h_q <= h_d; n_q <= n_d;
		if (fin) begin
			rh_q <= fin_rh[HANDLE_W-1:0];
			ok_q <= fin_ok;
			bb_q <= fin_bb[BYTES_W-1:0];
			bf_q <= fin_bf;
		end
	end

	assign busy          = (state_q != ST_IDLE) || init_busy;
	assign done          = done_q;
	assign result_handle = rh_q;
	assign ok            = ok_q;
	assign block_bytes   = bb_q;
	assign block_free    = bf_q;

endmodule

// ===== rtl/core/boundary_tag_allocator.sv =====
// First-fit heap allocator with boundary tags, kept in one word memory.
// Command channel: drive cmd, byte_count, handle and restart with start; the
// word is taken on a clock edge where start is high and busy is low.
// Result channel: done is high for one cycle with result_handle, ok,
// block_bytes and block_free; there is no back-pressure, the receiver must
// take the word in that cycle.
// Every memory access is a registered read or a write, issued one after
// another by the sequencer; how long an item takes depends on the command:
//   walk  : reads the tag of one block at the walk cursor
//   query : grows with each free block passed
//   alloc : grows with each free block visited before the fit, or visited
//           when nothing fits
//   free  : depends on which neighbors are free
// busy stays high from accept until the cycle done is raised.
// After reset a clearing pass writes every word, and the store then holds one
// free block spanning it; busy is high meanwhile.
module boundary_tag_allocator #(
	parameter int STORE_WORDS    = 1024,
	parameter int WORD_BYTES     = 4,
	parameter int FREE_TAG_WORDS = 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  bta_pkg::cmd_t                cmd,
	input  logic [bta_pkg::BYTES_W-1:0]  byte_count,
	input  logic [bta_pkg::HANDLE_W-1:0] handle,
	input  logic                         restart,
	output logic                         done,
	output logic [bta_pkg::HANDLE_W-1:0] result_handle,
	output logic                         ok,
	output logic [bta_pkg::BYTES_W-1:0]  block_bytes,
	output logic                         block_free
);
	import bta_pkg::*;

	localparam int LW = $clog2(STORE_WORDS);
	localparam int XW = (LW + 3 > 17) ? LW + 3 : 17;

	mem_ctl_t                     mc;
	logic signed [XW-1:0]         rd_addr, wr_addr, wr_data;
	logic signed [STORE_BITS-1:0] rd_data;
	logic                         init_busy;

	bta_store #(
		.STORE_WORDS(STORE_WORDS),
		.WORD_BYTES (WORD_BYTES),
		.ADDR_W     (XW)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.mc       (mc),
		.rd_addr  (rd_addr),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.rd_data  (rd_data),
		.init_busy(init_busy)
	);

	bta_ctrl #(
		.STORE_WORDS   (STORE_WORDS),
		.WORD_BYTES    (WORD_BYTES),
		.FREE_TAG_WORDS(FREE_TAG_WORDS),
		.ADDR_W        (XW)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.cmd          (cmd),
		.byte_count   (byte_count),
		.handle       (handle),
		.restart      (restart),
		.init_busy    (init_busy),
		.rd_data      (rd_data),
		.mc           (mc),
		.rd_addr      (rd_addr),
		.wr_addr      (wr_addr),
		.wr_data      (wr_data),
		.busy         (busy),
		.done         (done),
		.result_handle(result_handle),
		.ok           (ok),
		.block_bytes  (block_bytes),
		.block_free   (block_free)
	);

endmodule

// ===== rtl/core/bta_checker.sv =====
module bta_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         start,
	input logic                         busy,
	input logic                         done,
	input logic [bta_pkg::HANDLE_W-1:0] result_handle,
	input logic                         ok
);
	import bta_pkg::*;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted word did not raise busy");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result word while busy");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result word repeated");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !ok |-> result_handle == '0)
		else $error("handle without ok");

endmodule

bind boundary_tag_allocator bta_checker u_bta_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.done         (done),
	.result_handle(result_handle),
	.ok           (ok)
);
